// ===== sv/tcrs_pkg.sv =====
package tcrs_pkg;

   localparam int TCRS_MAX_TEXT_ROWS = 64;
   localparam int TCRS_MAX_TEXT_COLS = 128;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;

   localparam logic [6:0] ROWS_IN_USE_RESET = 7'd48;
   localparam logic [7:0] COLS_IN_USE_RESET = 8'd100;

   typedef enum logic [1:0] {
      CMD_PUT       = 2'd0,
      CMD_BACKSPACE = 2'd1,
      CMD_CLEAR     = 2'd2,
      CMD_READ      = 2'd3
   } tcrs_cmd_type;

   typedef enum logic {
      CSR_ROWS_IN_USE = 1'b0,
      CSR_COLS_IN_USE = 1'b1
   } tcrs_csr_type;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_DISPATCH,
      ST_NEWLINE,
      ST_TOP_MOD,
      ST_BOTTOM_MOD,
      ST_ROW_CLR,
      ST_CELL_MOD,
      ST_CELL_ACC,
      ST_READ_WAIT,
      ST_CLR_ALL,
      ST_RESP
   } tcrs_state_type;

endpackage

// ===== sv/tcrs_mod_unit.sv =====
// Restoring remainder, one dividend bit per cycle.
module tcrs_mod_unit #(
   parameter int DIVD_W = 7,
   parameter int DIVS_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVS_W-1:0] remainder
);

   localparam int CNT_W = (DIVD_W > 1) ? $clog2(DIVD_W) : 1;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] num_ff, num_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   divisor_ext;
   logic              last_step;

   assign divisor_ext = {1'b0, divisor};
   assign trial       = {rem_ff, num_ff[DIVD_W-1]};
   assign last_step   = (cnt_ff == CNT_W'(DIVD_W - 1));

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (run_ff) begin
         num_in = {num_ff[DIVD_W-2:0], 1'b0};
         if (trial >= divisor_ext) begin
            rem_in = DIVS_W'(trial - divisor_ext);
         end else begin
            rem_in = DIVS_W'(trial);
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_step) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (req && !done_ff) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = dividend;
         rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/text_console_ring_scroll_unit.sv =====
// Put, backspace and read locate their cell through the bit-serial row-modulo unit
// (RW = log2 of max rows); a newline without scroll does not use it.
// Scroll adds two modulo passes plus one row clear of 2^CW cells; clear screen sweeps the
// whole store of 2^(RW+CW) cells. One request at a time; busy stays high up to the strobe,
// next accept the cycle after; the receiver cannot stall.
// Reset: synchronous; the store is swept to zero (all 2^(RW+CW) cells) with busy high.
module text_console_ring_scroll_unit #(
   parameter int MAX_TEXT_ROWS = tcrs_pkg::TCRS_MAX_TEXT_ROWS,
   parameter int MAX_TEXT_COLS = tcrs_pkg::TCRS_MAX_TEXT_COLS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_command,
   input  logic [7:0] req_char_code,
   input  logic [5:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_valid,
   output logic       rsp_draw_valid,
   output logic [6:0] rsp_draw_col,
   output logic [5:0] rsp_draw_row,
   output logic [7:0] rsp_draw_char,
   output logic       rsp_repaint,
   output logic       rsp_screen_cleared,
   output logic [5:0] rsp_top_row,
   output logic [7:0] rsp_read_char,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   import tcrs_pkg::*;

   localparam int RW    = $clog2(MAX_TEXT_ROWS);
   localparam int RNW   = $clog2(MAX_TEXT_ROWS + 1);
   localparam int CW    = $clog2(MAX_TEXT_COLS);
   localparam int CNW   = $clog2(MAX_TEXT_COLS + 1);
   localparam int MW    = RW + 1;
   localparam int AW    = RW + CW;
   localparam int DEPTH = 2 ** AW;

   tcrs_state_type state_ff, state_in;
   tcrs_cmd_type   cmd_ff, cmd_in;

   logic [7:0]     code_ff, code_in;
   logic [5:0]     rrow_ff, rrow_in;
   logic [6:0]     rcol_ff, rcol_in;
   logic [CNW-1:0] cursor_col_ff, cursor_col_in;
   logic [RW-1:0]  cursor_row_ff, cursor_row_in;
   logic [RW-1:0]  top_ff, top_in;
   logic [RW-1:0]  phys_ff, phys_in;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic [6:0]     rows_in_use_ff, rows_in_use_in;
   logic [7:0]     cols_in_use_ff, cols_in_use_in;

   logic           draw_valid_ff, draw_valid_in;
   logic [6:0]     draw_col_ff, draw_col_in;
   logic [5:0]     draw_row_ff, draw_row_in;
   logic [7:0]     draw_char_ff, draw_char_in;
   logic           repaint_ff, repaint_in;
   logic           cleared_ff, cleared_in;
   logic [7:0]     read_char_ff, read_char_in;
   logic [7:0]     rd_data_ff;

   logic [RNW-1:0] rows_eff;
   logic [CNW-1:0] cols_eff;
   logic           accept;
   logic           read_in_view;
   logic           all_swept;
   logic           row_swept;

   logic           mod_req;
   logic [MW-1:0]  mod_dividend;
   logic           mod_done;
   logic [RNW-1:0] mod_rem;

   logic           mem_we;
   logic [AW-1:0]  mem_addr;
   logic [7:0]     mem_wdata;
   logic [CW-1:0]  cell_col;
   logic [7:0]     cell_mem [DEPTH];

   // Registers used saturated to 1..max.
   always_comb begin
      if (rows_in_use_ff == '0) begin
         rows_eff = RNW'(1);
      end else if (32'(rows_in_use_ff) > MAX_TEXT_ROWS) begin
         rows_eff = RNW'(MAX_TEXT_ROWS);
      end else begin
         rows_eff = RNW'(rows_in_use_ff);
      end
      if (cols_in_use_ff == '0) begin
         cols_eff = CNW'(1);
      end else if (32'(cols_in_use_ff) > MAX_TEXT_COLS) begin
         cols_eff = CNW'(MAX_TEXT_COLS);
      end else begin
         cols_eff = CNW'(cols_in_use_ff);
      end
   end

   assign accept       = start && (state_ff == ST_IDLE);
   assign read_in_view = (32'(rrow_ff) < 32'(rows_eff)) && (32'(rcol_ff) < 32'(cols_eff));
   assign all_swept    = (sweep_ff == {AW{1'b1}});
   assign row_swept    = (sweep_ff[CW-1:0] == {CW{1'b1}});
   assign cell_col     = (cmd_ff == CMD_READ) ? CW'(rcol_ff) : CW'(cursor_col_ff);

   always_comb begin
      case (state_ff)
         ST_TOP_MOD:    mod_dividend = MW'(top_ff) + MW'(1);
         ST_BOTTOM_MOD: mod_dividend = MW'(top_ff) + MW'(rows_eff - RNW'(1));
         ST_CELL_MOD: begin
            if (cmd_ff == CMD_READ) begin
               mod_dividend = MW'(top_ff) + MW'(rrow_ff);
            end else begin
               mod_dividend = MW'(top_ff) + MW'(cursor_row_ff);
            end
         end
         default:       mod_dividend = '0;
      endcase
   end

   tcrs_mod_unit #(
      .DIVD_W (MW),
      .DIVS_W (RNW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .req       (mod_req),
      .dividend  (mod_dividend),
      .divisor   (rows_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT_CLR: begin
            if (all_swept) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_PUT: begin
                  if (code_ff == NEWLINE_CODE || 32'(cursor_col_ff) >= 32'(cols_eff)) begin
                     state_in = ST_NEWLINE;
                  end else begin
                     state_in = ST_CELL_MOD;
                  end
               end
               CMD_BACKSPACE: state_in = (cursor_col_ff != '0) ? ST_CELL_MOD : ST_RESP;
               CMD_CLEAR:     state_in = ST_CLR_ALL;
               CMD_READ:      state_in = read_in_view ? ST_CELL_MOD : ST_RESP;
               default:       state_in = ST_RESP;
            endcase
         end
         ST_NEWLINE: begin
            if (32'(cursor_row_ff) + 1 < 32'(rows_eff)) begin
               state_in = (code_ff == NEWLINE_CODE) ? ST_RESP : ST_CELL_MOD;
            end else begin
               state_in = ST_TOP_MOD;
            end
         end
         ST_TOP_MOD: begin
            if (mod_done) state_in = ST_BOTTOM_MOD;
         end
         ST_BOTTOM_MOD: begin
            if (mod_done) state_in = ST_ROW_CLR;
         end
         ST_ROW_CLR: begin
            if (row_swept) state_in = (code_ff == NEWLINE_CODE) ? ST_RESP : ST_CELL_MOD;
         end
         ST_CELL_MOD: begin
            if (mod_done) state_in = ST_CELL_ACC;
         end
         ST_CELL_ACC:   state_in = (cmd_ff == CMD_READ) ? ST_READ_WAIT : ST_RESP;
         ST_READ_WAIT:  state_in = ST_RESP;
         ST_CLR_ALL: begin
            if (all_swept) state_in = ST_RESP;
         end
         ST_RESP:       state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      mod_req   = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = {phys_ff, cell_col};
      mem_wdata = '0;
      rsp_valid = 1'b0;
      busy      = 1'b1;
      case (state_ff)
         ST_INIT_CLR, ST_CLR_ALL: begin
            mem_we   = 1'b1;
            mem_addr = sweep_ff;
         end
         ST_IDLE:       busy = 1'b0;
         ST_ROW_CLR: begin
            mem_we   = 1'b1;
            mem_addr = {phys_ff, sweep_ff[CW-1:0]};
         end
         ST_TOP_MOD, ST_BOTTOM_MOD, ST_CELL_MOD: mod_req = 1'b1;
         ST_CELL_ACC: begin
            mem_we    = (cmd_ff != CMD_READ);
            mem_wdata = (cmd_ff == CMD_PUT) ? code_ff : 8'd0;
         end
         ST_RESP:       rsp_valid = 1'b1;
         default:       mod_req = 1'b0;
      endcase
   end

   // Datapath register updates
   always_comb begin
      cmd_in         = cmd_ff;
      code_in        = code_ff;
      rrow_in        = rrow_ff;
      rcol_in        = rcol_ff;
      cursor_col_in  = cursor_col_ff;
      cursor_row_in  = cursor_row_ff;
      top_in         = top_ff;
      phys_in        = phys_ff;
      sweep_in       = sweep_ff;
      rows_in_use_in = rows_in_use_ff;
      cols_in_use_in = cols_in_use_ff;
      draw_valid_in  = draw_valid_ff;
      draw_col_in    = draw_col_ff;
      draw_row_in    = draw_row_ff;
      draw_char_in   = draw_char_ff;
      repaint_in     = repaint_ff;
      cleared_in     = cleared_ff;
      read_char_in   = read_char_ff;

      if (csr_valid) begin
         case (tcrs_csr_type'(csr_index))
            CSR_ROWS_IN_USE: rows_in_use_in = csr_wdata[6:0];
            CSR_COLS_IN_USE: cols_in_use_in = csr_wdata;
            default:         rows_in_use_in = rows_in_use_ff;
         endcase
      end

      case (state_ff)
         ST_INIT_CLR, ST_CLR_ALL: begin
            sweep_in = sweep_ff + AW'(1);
            if (all_swept) begin
               top_in        = '0;
               cursor_col_in = '0;
               cursor_row_in = '0;
               cleared_in    = (state_ff == ST_CLR_ALL);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = tcrs_cmd_type'(req_command);
               code_in       = req_char_code;
               rrow_in       = req_read_row;
               rcol_in       = req_read_col;
               draw_valid_in = 1'b0;
               draw_col_in   = '0;
               draw_row_in   = '0;
               draw_char_in  = '0;
               repaint_in    = 1'b0;
               cleared_in    = 1'b0;
               read_char_in  = '0;
               // cursor left beyond a shrunk screen sits on the last row
               if (32'(cursor_row_ff) >= 32'(rows_eff)) begin
                  cursor_row_in = RW'(rows_eff - RNW'(1));
               end
            end
         end
         ST_DISPATCH: begin
            if (cmd_ff == CMD_BACKSPACE && cursor_col_ff != '0) begin
               cursor_col_in = cursor_col_ff - CNW'(1);
            end
         end
         ST_NEWLINE: begin
            cursor_col_in = '0;
            if (32'(cursor_row_ff) + 1 < 32'(rows_eff)) begin
               cursor_row_in = cursor_row_ff + RW'(1);
            end
         end
         ST_TOP_MOD: begin
            if (mod_done) top_in = RW'(mod_rem);
         end
         ST_BOTTOM_MOD: begin
            if (mod_done) begin
               phys_in       = RW'(mod_rem);
               cursor_row_in = RW'(rows_eff - RNW'(1));
               repaint_in    = 1'b1;
            end
         end
         ST_ROW_CLR: begin
            sweep_in = row_swept ? '0 : sweep_ff + AW'(1);
         end
         ST_CELL_MOD: begin
            if (mod_done) phys_in = RW'(mod_rem);
         end
         ST_CELL_ACC: begin
            if (cmd_ff != CMD_READ) begin
               draw_valid_in = 1'b1;
               draw_col_in   = 7'(cursor_col_ff);
               draw_row_in   = 6'(cursor_row_ff);
               draw_char_in  = (cmd_ff == CMD_PUT) ? code_ff : SPACE_CODE;
            end
            if (cmd_ff == CMD_PUT) cursor_col_in = cursor_col_ff + CNW'(1);
         end
         ST_READ_WAIT:  read_char_in = rd_data_ff;
         default:       sweep_in = sweep_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT_CLR;
         cursor_col_ff  <= '0;
         cursor_row_ff  <= '0;
         top_ff         <= '0;
         sweep_ff       <= '0;
         rows_in_use_ff <= ROWS_IN_USE_RESET;
         cols_in_use_ff <= COLS_IN_USE_RESET;
      end else begin
         state_ff       <= state_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_row_ff  <= cursor_row_in;
         top_ff         <= top_in;
         sweep_ff       <= sweep_in;
         rows_in_use_ff <= rows_in_use_in;
         cols_in_use_ff <= cols_in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      code_ff       <= code_in;
      rrow_ff       <= rrow_in;
      rcol_ff       <= rcol_in;
      phys_ff       <= phys_in;
      draw_valid_ff <= draw_valid_in;
      draw_col_ff   <= draw_col_in;
      draw_row_ff   <= draw_row_in;
      draw_char_ff  <= draw_char_in;
      repaint_ff    <= repaint_in;
      cleared_ff    <= cleared_in;
      read_char_ff  <= read_char_in;
   end

   // Cell store: one port, read data registered.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= cell_mem[mem_addr];
   end

   assign csr_ready          = 1'b1;
   assign rsp_draw_valid     = draw_valid_ff;
   assign rsp_draw_col       = draw_col_ff;
   assign rsp_draw_row       = draw_row_ff;
   assign rsp_draw_char      = draw_char_ff;
   assign rsp_repaint        = repaint_ff;
   assign rsp_screen_cleared = cleared_ff;
   assign rsp_top_row        = 6'(top_ff);
   assign rsp_read_char      = read_char_ff;

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not make the unit busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_screen_cleared) |-> (rsp_top_row == '0 && !rsp_draw_valid))
      else $error("clear result with nonzero top row or a draw");

   a_draw_row_visible: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_draw_valid) |-> (32'(draw_row_ff) < 32'(rows_eff)))
      else $error("draw row outside the visible rows");

   a_mod_done_owner: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_TOP_MOD || state_ff == ST_BOTTOM_MOD ||
                    state_ff == ST_CELL_MOD))
      else $error("modulo result arrived outside a modulo step");
`endif

endmodule
